### rtl/ifc_pkg.sv
// Shared types and constants for the integer field formatter.
package ifc_pkg;

  localparam int MAX_FIELD = 60;
  localparam int NDIG      = 22;  // octal needs 22 digits for 64 bits
  localparam int NBCD      = 20;

  localparam logic [2:0] FN_DEC = 3'd0;
  localparam logic [2:0] FN_UNS = 3'd1;
  localparam logic [2:0] FN_OCT = 3'd2;
  localparam logic [2:0] FN_HXL = 3'd3;
  localparam logic [2:0] FN_HXU = 3'd4;
  localparam logic [2:0] FN_PTR = 3'd5;
  localparam logic [2:0] FN_CHR = 3'd6;
  localparam logic [2:0] FN_PCT = 3'd7;

  localparam logic [1:0] LC_INT = 2'd0;
  localparam logic [1:0] LC_HH  = 2'd1;
  localparam logic [1:0] LC_H   = 2'd2;
  localparam logic [1:0] LC_L   = 2'd3;

  typedef enum logic [2:0] {
    SEG_PADL, SEG_PRE, SEG_ZPAD, SEG_PZ, SEG_DIG, SEG_PADR, SEG_PCT
  } seg_t;

  typedef struct packed {
    logic       load;
    logic       conv;
    logic       size;
    logic       calc_pz;
    logic       calc_pad;
    logic       emit;
    logic       last;
    seg_t       sel;
    logic [5:0] idx;
  } ifc_cmd_t;

  typedef struct packed {
    logic [5:0] seg_len;
    logic [5:0] total;
  } ifc_stat_t;

endpackage

### rtl/ifc_datapath.sv
// Datapath: argument conditioning, binary to BCD, digit sizing, field math, char select.
module ifc_datapath import ifc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ifc_cmd_t          cmd,
  output ifc_stat_t         stat,
  input  logic [2:0]        func,
  input  logic [63:0]       value,
  input  logic [1:0]        length_code,
  input  logic              left_align,
  input  logic              zero_pad,
  input  logic              alt_form,
  input  logic [5:0]        field_width,
  input  logic signed [6:0] precision,
  output logic [7:0]        char_out,
  output logic              last,
  output logic              strobe
);

  logic [2:0]            fn;
  logic                  la, zp, alt, neg, prec_on;
  logic [5:0]            width, prec;
  logic [63:0]           mag;
  logic [7:0]            cval;
  logic [4*NBCD-1:0]     bcd;
  logic [NDIG-1:0][3:0]  digs;
  logic [4:0]            dlen;
  logic [1:0]            plen;
  logic                  numeric, is_nil, oct_pre;
  logic [7:0]            pre0, pre1;
  logic [5:0]            pz, pad, total;

  logic [63:0]           masked, sext;
  logic                  sgn;
  logic [4*NBCD-1:0]     bcd_adj;
  logic [NDIG-1:0][3:0]  digs_next;
  logic [4:0]            hi;
  logic [65:0]           oct_src;
  logic                  mag_zero;
  logic [5:0]            used;
  logic [4:0]            pos;
  logic [3:0]            dsel;
  logic [7:0]            ch;

  // Conditioning of the raw argument by length code
  always_comb begin
    masked = value;
    sext   = value;
    sgn    = 1'b0;
    unique case (length_code)
      LC_INT: begin
        masked = {32'd0, value[31:0]};
        sext   = {{32{value[31]}}, value[31:0]};
        sgn    = value[31];
      end
      LC_HH: begin
        masked = {56'd0, value[7:0]};
        sext   = {{56{value[7]}}, value[7:0]};
        sgn    = value[7];
      end
      LC_H: begin
        masked = {48'd0, value[15:0]};
        sext   = {{48{value[15]}}, value[15:0]};
        sgn    = value[15];
      end
      default: begin
        masked = value;
        sext   = value;
        sgn    = value[63];
      end
    endcase
  end

  // Shift-add-3 adjust, each BCD digit on its own
  always_comb begin
    bcd_adj = bcd;
    for (int i = 0; i < NBCD; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
    end
  end

  assign oct_src  = {2'b00, mag};
  assign mag_zero = (mag == 64'd0);

  always_comb begin
    digs_next = '0;
    case (fn)
      FN_DEC, FN_UNS: begin
        for (int i = 0; i < NBCD; i++) digs_next[i] = bcd[4*i +: 4];
      end
      FN_OCT: begin
        for (int i = 0; i < NDIG; i++) digs_next[i] = {1'b0, oct_src[3*i +: 3]};
      end
      default: begin
        for (int i = 0; i < 16; i++) digs_next[i] = mag[4*i +: 4];
      end
    endcase
    hi = 5'd0;
    for (int i = 0; i < NDIG; i++) begin
      if (digs_next[i] != 4'd0) hi = 5'(i + 1);
    end
  end

  assign used = 6'(dlen) + 6'(plen) + pz;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fn      <= func;
      la      <= left_align;
      zp      <= zero_pad & ~left_align;
      alt     <= alt_form;
      width   <= (field_width > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : field_width;
      prec_on <= ~precision[6];
      prec    <= (precision[5:0] > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : precision[5:0];
      cval    <= value[7:0];
      bcd     <= '0;
      neg     <= 1'b0;
      if (func == FN_DEC && sgn) begin
        mag <= ~sext + 64'd1;
        neg <= 1'b1;
      end else if (func <= FN_HXU) begin
        mag <= masked;
      end else begin
        mag <= value;
      end
    end
    if (cmd.conv) begin
      bcd <= {bcd_adj[4*NBCD-2:0], mag[63]};
      mag <= {mag[62:0], 1'b0};
    end
    if (cmd.size) begin
      digs    <= digs_next;
      numeric <= 1'b1;
      is_nil  <= 1'b0;
      oct_pre <= 1'b0;
      plen    <= 2'd0;
      pre0    <= "0";
      pre1    <= (fn == FN_HXU) ? "X" : "x";
      dlen    <= (hi == 5'd0) ? 5'd1 : hi;
      case (fn)
        FN_DEC: begin
          if (neg) begin
            plen <= 2'd1;
            pre0 <= "-";
          end
        end
        FN_OCT: begin
          if (alt && !mag_zero) begin
            plen    <= 2'd1;
            oct_pre <= 1'b1;
          end
        end
        FN_HXL, FN_HXU: begin
          if (alt && !mag_zero) plen <= 2'd2;
        end
        FN_PTR: begin
          if (mag_zero) begin
            numeric <= 1'b0;
            is_nil  <= 1'b1;
            dlen    <= 5'd5;
          end else begin
            plen <= 2'd2;
          end
        end
        FN_CHR: begin
          numeric <= 1'b0;
          dlen    <= 5'd1;
        end
        default: ;
      endcase
    end
    if (cmd.calc_pz) begin
      if (numeric && prec_on && prec > 6'(dlen)) begin
        pz <= prec - 6'(dlen) - 6'(oct_pre);
      end else begin
        pz <= 6'd0;
      end
    end
    if (cmd.calc_pad) begin
      pad   <= (width > used) ? width - used : 6'd0;
      total <= (width > used) ? width : used;
    end
  end

  always_comb begin
    unique case (cmd.sel)
      SEG_PADL: stat.seg_len = (!zp && !la) ? pad : 6'd0;
      SEG_PRE:  stat.seg_len = 6'(plen);
      SEG_ZPAD: stat.seg_len = zp ? pad : 6'd0;
      SEG_PZ:   stat.seg_len = pz;
      SEG_DIG:  stat.seg_len = 6'(dlen);
      SEG_PADR: stat.seg_len = la ? pad : 6'd0;
      default:  stat.seg_len = 6'd1;
    endcase
    stat.total = total;
  end

  assign pos  = dlen - 5'd1 - cmd.idx[4:0];
  assign dsel = digs[pos];

  always_comb begin
    ch = " ";
    unique case (cmd.sel)
      SEG_PADL, SEG_PADR: ch = " ";
      SEG_PRE:            ch = (cmd.idx == 6'd0) ? pre0 : pre1;
      SEG_ZPAD, SEG_PZ:   ch = "0";
      SEG_PCT:            ch = "%";
      default: begin
        if (is_nil) begin
          case (cmd.idx[2:0])
            3'd0:    ch = "(";
            3'd1:    ch = "n";
            3'd2:    ch = "i";
            3'd3:    ch = "l";
            default: ch = ")";
          endcase
        end else if (fn == FN_CHR) begin
          ch = cval;
        end else if (dsel < 4'd10) begin
          ch = 8'("0") + 8'(dsel);
        end else if (fn == FN_HXU) begin
          ch = 8'("A") + 8'(dsel) - 8'd10;
        end else begin
          ch = 8'("a") + 8'(dsel) - 8'd10;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      strobe <= cmd.emit;
      last   <= cmd.emit & cmd.last;
    end
    if (cmd.emit) char_out <= ch;
  end

endmodule

### rtl/ifc_ctrl.sv
// Controller: sequences conversion, sizing and the emission of each field segment.
module ifc_ctrl import ifc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [2:0] func,
  input  ifc_stat_t stat,
  output ifc_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_CONV, S_SIZE, S_PZC, S_PADC, S_ARM,
    S_PADL, S_PRE, S_ZPAD, S_PZ, S_DIG, S_PADR, S_PCT
  } state_t;

  state_t     state;
  logic [5:0] idx;
  logic [5:0] left;
  logic       in_seg;
  logic       seg_done;

  function automatic state_t after_seg(state_t s);
    unique case (s)
      S_PADL:  return S_PRE;
      S_PRE:   return S_ZPAD;
      S_ZPAD:  return S_PZ;
      S_PZ:    return S_DIG;
      S_DIG:   return S_PADR;
      default: return S_IDLE;
    endcase
  endfunction

  assign in_seg   = (state == S_PADL) || (state == S_PRE) || (state == S_ZPAD) ||
                    (state == S_PZ) || (state == S_DIG) || (state == S_PADR);
  assign seg_done = (idx == stat.seg_len);
  assign busy     = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && start;
    cmd.conv     = (state == S_CONV);
    cmd.size     = (state == S_SIZE);
    cmd.calc_pz  = (state == S_PZC);
    cmd.calc_pad = (state == S_PADC);
    cmd.emit     = (in_seg && !seg_done) || (state == S_PCT);
    cmd.last     = (state == S_PCT) || (left == 6'd1);
    cmd.idx      = idx;
    unique case (state)
      S_PRE:   cmd.sel = SEG_PRE;
      S_ZPAD:  cmd.sel = SEG_ZPAD;
      S_PZ:    cmd.sel = SEG_PZ;
      S_DIG:   cmd.sel = SEG_DIG;
      S_PADR:  cmd.sel = SEG_PADR;
      S_PCT:   cmd.sel = SEG_PCT;
      default: cmd.sel = SEG_PADL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= 6'd0;
      left  <= 6'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          idx <= 6'd0;
          if (start) begin
            if (func == FN_PCT)                        state <= S_PCT;
            else if (func == FN_DEC || func == FN_UNS) state <= S_CONV;
            else                                       state <= S_SIZE;
          end
        end
        S_CONV: begin
          idx <= idx + 6'd1;
          if (idx == 6'd63) state <= S_SIZE;
        end
        S_SIZE: state <= S_PZC;
        S_PZC:  state <= S_PADC;
        S_PADC: state <= S_ARM;
        S_ARM: begin
          left  <= stat.total;
          idx   <= 6'd0;
          state <= S_PADL;
        end
        S_PCT: state <= S_IDLE;
        S_PADL, S_PRE, S_ZPAD, S_PZ, S_DIG, S_PADR: begin
          if (seg_done) begin
            idx   <= 6'd0;
            state <= after_seg(state);
          end else begin
            idx  <= idx + 6'd1;
            left <= left - 6'd1;
            if (left == 6'd1) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (in_seg || state == S_PCT))
    else $error("emit outside an emission state");
  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && in_seg) |-> (left != 6'd0))
    else $error("beat emitted with no characters left");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == S_IDLE))
    else $error("not idle after last beat");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_CONV || state == S_SIZE || state == S_PCT))
    else $error("bad state after load");
`endif

endmodule

### rtl/integer_field_formatter_core.sv
// Top level of the integer field formatter: controller plus datapath.
//
// Formats one printf-style integer conversion and sends its characters out.
// Input: a conversion is taken on a clock edge where start is high and busy
// is low; func, value, length_code, the flags, field_width and precision are
// sampled on that edge only. busy stays high until the last character beat
// has been issued.
// Output: each character appears on char_out for one cycle with strobe high;
// last is high on the final beat. The receiver cannot stall the stream.
// Sequence: d/i and u run a bit-serial binary to BCD conversion, then digit
// sizing and field arithmetic, then one character per cycle, with a closing
// step for each segment ahead of the one holding the last character. Beats
// leave through an output register. Other conversions skip the BCD phase;
// '%' gives a single beat.
// A new conversion is taken only after the last one has returned to idle,
// so conversions never overlap; for d/i and u the bit-serial BCD converter
// sets the pace.
// Reset (rst, synchronous) returns the controller to idle and drops strobe.
module integer_field_formatter_core import ifc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        func,
  input  logic [63:0]       value,
  input  logic [1:0]        length_code,
  input  logic              left_align,
  input  logic              zero_pad,
  input  logic              alt_form,
  input  logic [5:0]        field_width,
  input  logic signed [6:0] precision,
  output logic [7:0]        char_out,
  output logic              last,
  output logic              strobe
);

  ifc_cmd_t  cmd;
  ifc_stat_t stat;

  ifc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ifc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .value       (value),
    .length_code (length_code),
    .left_align  (left_align),
    .zero_pad    (zero_pad),
    .alt_form    (alt_form),
    .field_width (field_width),
    .precision   (precision),
    .char_out    (char_out),
    .last        (last),
    .strobe      (strobe)
  );

endmodule

### sim/integer_field_formatter_core_test.sv
// Testbench for integer_field_formatter_core: directed and random conversions, char checks.
`timescale 1ns / 1ps
module integer_field_formatter_core_test;
  import ifc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] func = FN_DEC;
  logic [63:0] value = '0;
  logic [1:0] length_code = LC_INT;
  logic left_align = 1'b0;
  logic zero_pad = 1'b0;
  logic alt_form = 1'b0;
  logic [5:0] field_width = '0;
  logic signed [6:0] precision = -7'sd1;
  logic [7:0] char_out;
  logic last;
  logic strobe;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } char_beat_t;

  char_beat_t expected_chars[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  localparam int CYCLE_LIMIT = 400000;

  integer_field_formatter_core i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("integer_field_formatter_core_test: done, errors");
      $finish;
    end
  end

  // check each character beat against the oldest expectation
  always @(posedge clk) begin
    char_beat_t e;
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat char=%h last=%b", char_out, last);
      end else begin
        e = expected_chars.pop_front();
        if (e.ch !== char_out || e.lst !== last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp char=%h last=%b got char=%h last=%b",
                     e.ch, e.lst, char_out, last);
        end
      end
    end
  end

  function automatic void push_run(input logic [7:0] c, input int cnt);
    for (int k = 0; k < cnt; k++) expected_chars.push_back('{c, 1'b0});
  endfunction

  // compute the characters of one conversion and queue them
  function automatic void predict_field(input logic [2:0] fn, input logic [63:0] val,
      input logic [1:0] lc, input logic la, input logic zp_in, input logic alt,
      input logic [5:0] fw, input logic signed [6:0] pr);
    logic [7:0] pre[2];
    logic [7:0] dig[$];
    logic [63:0] v;
    logic [63:0] sbit;
    int plen, dlen, wid, prc, pz, pad;
    logic zp, numeric, oct_pre;
    string hexset;
    string nil_txt;
    nil_txt = "(nil)";
    zp = zp_in && !la;
    numeric = 1'b1;
    oct_pre = 1'b0;
    plen = 0;
    pz = 0;
    pad = 0;
    v = val;
    wid = (fw > MAX_FIELD) ? MAX_FIELD : fw;
    prc = (pr < 0) ? -1 : ((pr > MAX_FIELD) ? MAX_FIELD : pr);
    if (fn == FN_PCT) begin
      expected_chars.push_back('{8'h25, 1'b1});
      return;
    end
    if (fn <= FN_HXU) begin
      case (lc)
        LC_INT: v = v & 64'hFFFF_FFFF;
        LC_HH:  v = v & 64'hFF;
        LC_H:   v = v & 64'hFFFF;
        default: ;
      endcase
    end
    hexset = (fn == FN_HXU) ? "0123456789ABCDEF" : "0123456789abcdef";
    case (fn)
      FN_DEC, FN_UNS: begin
        if (fn == FN_DEC) begin
          sbit = (lc == LC_INT) ? 64'h8000_0000 : (lc == LC_HH) ? 64'h80 :
                 (lc == LC_H) ? 64'h8000 : 64'h8000_0000_0000_0000;
          if ((v & sbit) != 0) begin
            v = -(v | ~(sbit - 1));
            pre[0] = "-";
            plen = 1;
          end
        end
        do begin dig.push_front(8'(v % 10) + 8'h30); v = v / 10; end while (v != 0);
      end
      FN_OCT: begin
        if (alt && v != 0) begin pre[0] = "0"; plen = 1; oct_pre = 1'b1; end
        do begin dig.push_front(8'(v % 8) + 8'h30); v = v / 8; end while (v != 0);
      end
      FN_HXL, FN_HXU, FN_PTR: begin
        if (fn == FN_PTR && v == 0) begin
          numeric = 1'b0;
          foreach (nil_txt[k]) dig.push_back(nil_txt[k]);
        end else begin
          if ((alt || fn == FN_PTR) && v != 0) begin
            pre[0] = "0";
            pre[1] = (fn == FN_HXU) ? "X" : "x";
            plen = 2;
          end
          do begin dig.push_front(hexset[v % 16]); v = v / 16; end while (v != 0);
        end
      end
      default: begin
        numeric = 1'b0;
        dig.push_back(val[7:0]);
      end
    endcase
    dlen = dig.size();
    if (numeric && prc >= 0 && prc > dlen) begin
      pz = prc - dlen;
      if (oct_pre) pz--;
    end
    if (wid > dlen + plen + pz) pad = wid - dlen - plen - pz;
    if (!zp && !la) push_run(" ", pad);
    for (int k = 0; k < plen; k++) expected_chars.push_back('{pre[k], 1'b0});
    if (zp) push_run("0", pad);
    push_run("0", pz);
    foreach (dig[k]) expected_chars.push_back('{dig[k], 1'b0});
    if (la) push_run(" ", pad);
    expected_chars[$].lst = 1'b1;
  endfunction

  // called at a falling edge; start stays high until the next call or the end
  task automatic send_conversion(input logic [2:0] fn, input logic [63:0] val,
      input logic [1:0] lc, input logic la, input logic zp, input logic alt,
      input logic [5:0] fw, input logic signed [6:0] pr);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    func <= fn; value <= val; length_code <= lc; left_align <= la;
    zero_pad <= zp; alt_form <= alt; field_width <= fw; precision <= pr;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_field(fn, val, lc, la, zp, alt, fw, pr);
    @(negedge clk);
  endtask

  task automatic test_directed;
    send_conversion(FN_DEC, 64'h0, LC_INT, 0, 0, 0, 0, -1);
    send_conversion(FN_DEC, 64'h8000_0000, LC_INT, 0, 1, 0, 20, 12);
    send_conversion(FN_DEC, 64'h8000_0000_0000_0000, LC_L, 0, 0, 0, 0, -1);
    send_conversion(FN_DEC, 64'hFF, LC_HH, 1, 1, 0, 8, -1);
    send_conversion(FN_DEC, 64'h1234_8000, LC_H, 0, 0, 0, 63, 63);
    send_conversion(FN_UNS, '1, LC_L, 0, 0, 0, 0, 0);
    send_conversion(FN_UNS, 64'h0, LC_INT, 0, 0, 0, 0, 0);
    send_conversion(FN_OCT, '1, LC_L, 0, 0, 1, 30, 25);
    send_conversion(FN_OCT, 64'h8, LC_INT, 0, 0, 1, 0, 4);
    send_conversion(FN_OCT, 64'h0, LC_INT, 0, 0, 1, 5, -1);
    send_conversion(FN_HXL, 64'hABCD, LC_H, 0, 1, 1, 12, -1);
    send_conversion(FN_HXU, '1, LC_L, 1, 0, 1, 60, 40);
    send_conversion(FN_HXL, 64'h0, LC_INT, 0, 0, 1, 0, -1);
    send_conversion(FN_PTR, 64'h0, LC_INT, 0, 1, 0, 10, 20);
    send_conversion(FN_PTR, 64'h0, LC_INT, 1, 0, 0, 10, -1);
    send_conversion(FN_PTR, 64'hDEAD_BEEF_0000_0001, LC_HH, 0, 1, 0, 30, -1);
    send_conversion(FN_CHR, 64'h41, LC_INT, 0, 1, 0, 5, 9);
    send_conversion(FN_CHR, 64'hFF, LC_L, 1, 0, 0, 3, -1);
    send_conversion(FN_PCT, '1, LC_L, 1, 1, 1, 50, 30);
    send_conversion(FN_DEC, 64'h7FFF_FFFF_FFFF_FFFF, LC_L, 0, 1, 0, 62, -64);
  endtask

  task automatic test_random(input int count, input int idle);
    logic [63:0] val;
    logic signed [6:0] pr;
    idle_pct = idle;
    for (int i = 0; i < count; i++) begin
      val = {$urandom, $urandom};
      case ($urandom_range(3))
        0: val = val >> $urandom_range(63);
        1: val = 64'($urandom_range(9));
        default: ;
      endcase
      // mostly small fields and precisions, sometimes drawn from the full range
      pr = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($signed($urandom_range(24)) - 1);
      send_conversion(3'($urandom), val, 2'($urandom), 1'($urandom), 1'($urandom),
                      1'($urandom),
                      ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(16)),
                      pr);
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(100, 0);
    test_random(100, 75);
    test_random(100, 31);
    test_random(100, 0);
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("integer_field_formatter_core_test: done, clean");
    else
      $display("integer_field_formatter_core_test: done, errors");
    $finish;
  end

endmodule
